// File: hw/rtl/dowbe_pkg.sv
`timescale 1ns / 1ps

package dowbe_pkg;

   // Slot timer width default; a top level parameter overrides it.
   localparam int unsigned TIMER_BITS_DEF = 8;

   // Field widths.
   localparam int unsigned CMD_BITS       = 2;
   localparam int unsigned BYTE_BITS      = 8;
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 8;

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd2;

   // Register indices.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_TIME      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRITE_HOLD    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECOVERY_TIME = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_DELAY  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_READ_REST     = 3'd4;

   // Register reset values.
   localparam logic [CSR_DATA_BITS-1:0] LOW_TIME_RST      = 8'd2;
   localparam logic [CSR_DATA_BITS-1:0] WRITE_HOLD_RST    = 8'd110;
   localparam logic [CSR_DATA_BITS-1:0] RECOVERY_TIME_RST = 8'd2;
   localparam logic [CSR_DATA_BITS-1:0] SAMPLE_DELAY_RST  = 8'd2;
   localparam logic [CSR_DATA_BITS-1:0] READ_REST_RST     = 8'd90;

   // Slot sequencer phases, one-hot.
   typedef enum logic [7:0] {
      PH_IDLE   = 8'b0000_0001,
      PH_W_LOW  = 8'b0000_0010,
      PH_W_HOLD = 8'b0000_0100,
      PH_W_REC  = 8'b0000_1000,
      PH_R_LOW  = 8'b0001_0000,
      PH_R_WAIT = 8'b0010_0000,
      PH_R_SAMP = 8'b0100_0000,
      PH_R_REST = 8'b1000_0000
   } phase_type;

endpackage

// File: hw/rtl/dowbe_ifs.sv
`timescale 1ns / 1ps

// Tick request channel.
interface dowbe_req_if;
   import dowbe_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_BITS-1:0] cmd;
   logic [BYTE_BITS-1:0] wr_byte;
   logic                line_a;
   logic                line_b;

   modport source (output valid, cmd, wr_byte, line_a, line_b, input ready);
   modport sink   (input valid, cmd, wr_byte, line_a, line_b, output ready);
endinterface

// Per-tick result channel.
interface dowbe_rsp_if;
   import dowbe_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 line_release;
   logic                 busy_res;
   logic                 byte_done;
   logic [BYTE_BITS-1:0] read_byte_a;
   logic [BYTE_BITS-1:0] read_byte_b;
   logic                 cmd_ignored;

   modport source (output valid, line_release, busy_res, byte_done, read_byte_a,
                   read_byte_b, cmd_ignored, input ready);
   modport sink   (input valid, line_release, busy_res, byte_done, read_byte_a,
                   read_byte_b, cmd_ignored, output ready);
endinterface

// Register write channel.
interface dowbe_csr_if;
   import dowbe_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] reg_index;
   logic [CSR_DATA_BITS-1:0]  wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// File: hw/rtl/dual_one_wire_byte_engine_unit.sv
`timescale 1ns / 1ps

// Channel    | Dir | Payload                                         | Item
// -----------+-----+-------------------------------------------------+-----------------------
// req_chan   | in  | cmd, wr_byte, line_a, line_b                    | one microsecond tick
// rsp_chan   | out | line_release, busy_res, byte_done, read_byte_a/b,| result of one tick
//            |     | cmd_ignored                                     |
// csr_chan   | in  | reg_index, wr_data                              | one register write
//
// One item per cycle unless rsp stalls: the slot sequencer advances by one tick in the cycle
// an item is accepted, and its result lands in the output register on the same edge.
// A new item is taken while the output register is empty or being drained, so a stalled
// rsp side holds one result and backs up req only then.
// Reset (synchronous, active high) idles the sequencer and loads the register defaults.
// Register writes are always accepted; they act when the next phase is loaded.

module dual_one_wire_byte_engine_unit #(
   parameter int unsigned TIMER_BITS = dowbe_pkg::TIMER_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   dowbe_req_if.sink   req_chan,
   dowbe_rsp_if.source rsp_chan,
   dowbe_csr_if.sink   csr_chan
);
   import dowbe_pkg::*;

   // Width wide enough to compare an 8-bit register with the timer's top count.
   localparam int unsigned LOAD_BITS = ((TIMER_BITS > CSR_DATA_BITS) ? TIMER_BITS
                                                                     : CSR_DATA_BITS) + 1;
   localparam logic [LOAD_BITS-1:0] TIMER_TOP = LOAD_BITS'((1 << TIMER_BITS) - 1);

   // Timer load: zero lasts one tick, oversize saturates.
   function automatic logic [TIMER_BITS-1:0] timer_load(input logic [CSR_DATA_BITS-1:0] v);
      logic [LOAD_BITS-1:0] w;
      w = LOAD_BITS'(v);
      if (w == '0) begin
         w = LOAD_BITS'(1);
      end
      if (w > TIMER_TOP) begin
         w = TIMER_TOP;
      end
      return w[TIMER_BITS-1:0];
   endfunction

   // ---------------- configuration registers ----------------
   logic [CSR_DATA_BITS-1:0] low_time_ff,      low_time_in;
   logic [CSR_DATA_BITS-1:0] write_hold_ff,    write_hold_in;
   logic [CSR_DATA_BITS-1:0] recovery_time_ff, recovery_time_in;
   logic [CSR_DATA_BITS-1:0] sample_delay_ff,  sample_delay_in;
   logic [CSR_DATA_BITS-1:0] read_rest_ff,     read_rest_in;
   logic                     csr_wr;

   assign csr_chan.ready = 1'b1;
   assign csr_wr         = csr_chan.valid & csr_chan.ready;

   always_comb begin
      low_time_in      = low_time_ff;
      write_hold_in    = write_hold_ff;
      recovery_time_in = recovery_time_ff;
      sample_delay_in  = sample_delay_ff;
      read_rest_in     = read_rest_ff;
      if (csr_wr) begin
         unique case (csr_chan.reg_index)
            CSR_LOW_TIME:      low_time_in      = csr_chan.wr_data;
            CSR_WRITE_HOLD:    write_hold_in    = csr_chan.wr_data;
            CSR_RECOVERY_TIME: recovery_time_in = csr_chan.wr_data;
            CSR_SAMPLE_DELAY:  sample_delay_in  = csr_chan.wr_data;
            CSR_READ_REST:     read_rest_in     = csr_chan.wr_data;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_time_ff      <= LOW_TIME_RST;
         write_hold_ff    <= WRITE_HOLD_RST;
         recovery_time_ff <= RECOVERY_TIME_RST;
         sample_delay_ff  <= SAMPLE_DELAY_RST;
         read_rest_ff     <= READ_REST_RST;
      end else begin
         low_time_ff      <= low_time_in;
         write_hold_ff    <= write_hold_in;
         recovery_time_ff <= recovery_time_in;
         sample_delay_ff  <= sample_delay_in;
         read_rest_ff     <= read_rest_in;
      end
   end

   // ---------------- handshake ----------------
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;
   assign rsp_valid_in   = accept | (rsp_valid_ff & ~rsp_chan.ready);

   // ---------------- slot sequencer ----------------
   phase_type               slot_phase_ff, slot_phase_in;
   logic [TIMER_BITS-1:0]   tick_left_ff,  tick_left_in;
   logic [2:0]              bit_index_ff,  bit_index_in;
   logic [BYTE_BITS-1:0]    send_shift_ff, send_shift_in;
   logic [BYTE_BITS-1:0]    recv_a_ff,     recv_a_in;
   logic [BYTE_BITS-1:0]    recv_b_ff,     recv_b_in;

   // result of the tick being accepted
   logic                    release_in, busy_in, done_in, ign_in;
   logic [BYTE_BITS-1:0]    ra_in, rb_in;
   logic                    start;

   assign start = (req_chan.cmd == CMD_WRITE) || (req_chan.cmd == CMD_READ);

   always_comb begin
      slot_phase_in = slot_phase_ff;
      tick_left_in  = tick_left_ff;
      bit_index_in  = bit_index_ff;
      send_shift_in = send_shift_ff;
      recv_a_in     = recv_a_ff;
      recv_b_in     = recv_b_ff;
      release_in    = 1'b1;
      busy_in       = 1'b0;
      done_in       = 1'b0;
      ign_in        = 1'b0;
      ra_in         = '0;
      rb_in         = '0;

      // command decode: launch from idle, flag if already running
      if (slot_phase_ff != PH_IDLE) begin
         ign_in = start;
      end else if (start) begin
         bit_index_in = '0;
         tick_left_in = timer_load(low_time_ff);
         if (req_chan.cmd == CMD_WRITE) begin
            send_shift_in = req_chan.wr_byte;
            slot_phase_in = PH_W_LOW;
         end else begin
            recv_a_in     = '0;
            recv_b_in     = '0;
            slot_phase_in = PH_R_LOW;
         end
      end

      // this tick of the current (or just launched) slot
      if (slot_phase_in != PH_IDLE) begin
         busy_in = 1'b1;
         unique case (slot_phase_in)
            PH_W_LOW, PH_R_LOW: release_in = 1'b0;
            PH_W_HOLD:          release_in = send_shift_in[0];
            PH_R_SAMP: begin
               recv_a_in = {req_chan.line_a, recv_a_in[BYTE_BITS-1:1]};
               recv_b_in = {req_chan.line_b, recv_b_in[BYTE_BITS-1:1]};
            end
            default: ;
         endcase

         tick_left_in = tick_left_in - TIMER_BITS'(1);
         if (tick_left_in == '0) begin
            unique case (slot_phase_in)
               PH_W_LOW: begin
                  slot_phase_in = PH_W_HOLD;
                  tick_left_in  = timer_load(write_hold_ff);
               end
               PH_W_HOLD: begin
                  slot_phase_in = PH_W_REC;
                  tick_left_in  = timer_load(recovery_time_ff);
               end
               PH_R_LOW: begin
                  slot_phase_in = PH_R_WAIT;
                  tick_left_in  = timer_load(sample_delay_ff);
               end
               PH_R_WAIT: begin
                  slot_phase_in = PH_R_SAMP;
                  tick_left_in  = TIMER_BITS'(1);
               end
               PH_R_SAMP: begin
                  slot_phase_in = PH_R_REST;
                  tick_left_in  = timer_load(read_rest_ff);
               end
               default: begin
                  // end of a write recovery or read rest: slot complete
                  if (slot_phase_in == PH_W_REC) begin
                     send_shift_in = {1'b0, send_shift_in[BYTE_BITS-1:1]};
                  end
                  if (bit_index_in == 3'd7) begin
                     done_in = 1'b1;
                     if (slot_phase_in == PH_R_REST) begin
                        ra_in = recv_a_in;
                        rb_in = recv_b_in;
                     end
                     bit_index_in  = '0;
                     slot_phase_in = PH_IDLE;
                     tick_left_in  = '0;
                  end else begin
                     bit_index_in = bit_index_in + 3'd1;
                     tick_left_in = timer_load(low_time_ff);
                     slot_phase_in = (slot_phase_in == PH_W_REC) ? PH_W_LOW : PH_R_LOW;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_phase_ff <= PH_IDLE;
         tick_left_ff  <= '0;
         bit_index_ff  <= '0;
         send_shift_ff <= '0;
         recv_a_ff     <= '0;
         recv_b_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            slot_phase_ff <= slot_phase_in;
            tick_left_ff  <= tick_left_in;
            bit_index_ff  <= bit_index_in;
            send_shift_ff <= send_shift_in;
            recv_a_ff     <= recv_a_in;
            recv_b_ff     <= recv_b_in;
         end
      end
   end

   // ---------------- output register ----------------
   logic                 rsp_release_ff, rsp_busy_ff, rsp_done_ff, rsp_ign_ff;
   logic [BYTE_BITS-1:0] rsp_ra_ff, rsp_rb_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_release_ff <= release_in;
         rsp_busy_ff    <= busy_in;
         rsp_done_ff    <= done_in;
         rsp_ign_ff     <= ign_in;
         rsp_ra_ff      <= ra_in;
         rsp_rb_ff      <= rb_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.line_release = rsp_release_ff;
   assign rsp_chan.busy_res     = rsp_busy_ff;
   assign rsp_chan.byte_done    = rsp_done_ff;
   assign rsp_chan.read_byte_a  = rsp_ra_ff;
   assign rsp_chan.read_byte_b  = rsp_rb_ff;
   assign rsp_chan.cmd_ignored  = rsp_ign_ff;

   // ---------------- assertions ----------------
   // timer is non-zero exactly while a slot runs
   a_timer_idle: assert property (@(posedge clock) disable iff (reset)
      (slot_phase_ff == PH_IDLE) == (tick_left_ff == '0))
      else $error("slot timer out of step with phase");

   // bit counter only moves inside a transfer
   a_bit_idle: assert property (@(posedge clock) disable iff (reset)
      (slot_phase_ff == PH_IDLE) |-> (bit_index_ff == '0))
      else $error("bit index non-zero while idle");

   // done and ignored results only in busy ticks
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_done_ff || rsp_ign_ff)) |-> rsp_busy_ff)
      else $error("done or ignored flag outside a transfer");

   // read bytes shown only on the done tick
   a_bytes_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ra_ff != '0 || rsp_rb_ff != '0)) |-> rsp_done_ff)
      else $error("read byte shown outside done tick");

   // a completed transfer leaves the sequencer idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && done_in) |=> (slot_phase_ff == PH_IDLE))
      else $error("sequencer not idle after done");

endmodule

// File: tb/dual_one_wire_byte_engine_unit_tb.sv
`timescale 1ns / 1ps

module dual_one_wire_byte_engine_unit_tb;
   import dowbe_pkg::*;

   // Timer width of the instance under test (default parameter).
   localparam int unsigned TB_TIMER    = TIMER_BITS_DEF;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned HOLD_CYCLES = 120;
   // Spare command code: the block treats it as a plain tick.
   localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;

   // One tick item as offered on the request channel.
   typedef struct packed {
      logic [CMD_BITS-1:0]  cmd;
      logic [BYTE_BITS-1:0] wr_byte;
      logic                 line_a;
      logic                 line_b;
   } tick_type;

   // Result of one tick.
   typedef struct packed {
      logic                 line_release;
      logic                 busy_res;
      logic                 byte_done;
      logic [BYTE_BITS-1:0] read_byte_a;
      logic [BYTE_BITS-1:0] read_byte_b;
      logic                 cmd_ignored;
   } tick_result_type;

   logic clock;
   logic reset;

   dowbe_req_if req_if ();
   dowbe_rsp_if rsp_if ();
   dowbe_csr_if csr_if ();

   dual_one_wire_byte_engine_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------------------------------------------------------------------
   // Slot sequencer model: own copy of timing registers and sequencer state.
   // ---------------------------------------------------------------------------
   logic [CSR_DATA_BITS-1:0] cfg_low      = LOW_TIME_RST;
   logic [CSR_DATA_BITS-1:0] cfg_hold     = WRITE_HOLD_RST;
   logic [CSR_DATA_BITS-1:0] cfg_recovery = RECOVERY_TIME_RST;
   logic [CSR_DATA_BITS-1:0] cfg_sample   = SAMPLE_DELAY_RST;
   logic [CSR_DATA_BITS-1:0] cfg_rest     = READ_REST_RST;

   phase_type            eng_phase = PH_IDLE;
   logic [TB_TIMER-1:0]  eng_left  = '0;
   logic [2:0]           eng_bit   = '0;
   logic [BYTE_BITS-1:0] eng_tx    = '0;
   logic [BYTE_BITS-1:0] eng_rx_a  = '0;
   logic [BYTE_BITS-1:0] eng_rx_b  = '0;

   // Ticks a phase lasts for a register value: zero means one, and the
   // count saturates at the largest timer value.
   function automatic int unsigned timer_count(logic [CSR_DATA_BITS-1:0] v);
      int unsigned top;
      int unsigned n;
      top = (32'd1 << TB_TIMER) - 32'd1;
      n   = (v == '0) ? 32'd1 : 32'(v);
      if (n > top) n = top;
      return n;
   endfunction

   function automatic void load_phase(phase_type ph, logic [CSR_DATA_BITS-1:0] v);
      int unsigned n;
      n         = timer_count(v);
      eng_phase = ph;
      eng_left  = n[TB_TIMER-1:0];
   endfunction

   // Advances the sequencer by one tick and returns the result of that tick.
   function automatic tick_result_type engine_tick(tick_type t);
      tick_result_type r;
      logic            start;
      r              = '0;
      r.line_release = 1'b1;
      start          = (t.cmd == CMD_WRITE) || (t.cmd == CMD_READ);

      if (eng_phase != PH_IDLE) begin
         if (start) r.cmd_ignored = 1'b1;
      end else if (start) begin
         eng_bit = '0;
         if (t.cmd == CMD_WRITE) begin
            eng_tx = t.wr_byte;
            load_phase(PH_W_LOW, cfg_low);
         end else begin
            eng_rx_a = '0;
            eng_rx_b = '0;
            load_phase(PH_R_LOW, cfg_low);
         end
      end

      if (eng_phase != PH_IDLE) begin
         r.busy_res = 1'b1;
         case (eng_phase)
            PH_W_LOW, PH_R_LOW: r.line_release = 1'b0;
            PH_W_HOLD: r.line_release = eng_tx[0];
            PH_R_SAMP: begin
               // bits come in from the top, so the byte ends up LSB first
               eng_rx_a = {t.line_a, eng_rx_a[BYTE_BITS-1:1]};
               eng_rx_b = {t.line_b, eng_rx_b[BYTE_BITS-1:1]};
            end
            default: ;
         endcase

         eng_left = eng_left - 1'b1;
         if (eng_left == '0) begin
            case (eng_phase)
               PH_W_LOW:  load_phase(PH_W_HOLD, cfg_hold);
               PH_W_HOLD: load_phase(PH_W_REC, cfg_recovery);
               PH_R_LOW:  load_phase(PH_R_WAIT, cfg_sample);
               PH_R_WAIT: load_phase(PH_R_SAMP, 8'd1);
               PH_R_SAMP: load_phase(PH_R_REST, cfg_rest);
               default: begin
                  // end of a write or read slot
                  if (eng_phase == PH_W_REC) eng_tx = eng_tx >> 1;
                  if (eng_bit == 3'd7) begin
                     r.byte_done = 1'b1;
                     if (eng_phase == PH_R_REST) begin
                        r.read_byte_a = eng_rx_a;
                        r.read_byte_b = eng_rx_b;
                     end
                     eng_bit   = '0;
                     eng_phase = PH_IDLE;
                     eng_left  = '0;
                  end else begin
                     eng_bit = eng_bit + 1'b1;
                     load_phase((eng_phase == PH_W_REC) ? PH_W_LOW : PH_R_LOW, cfg_low);
                  end
               end
            endcase
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Bookkeeping
   // ---------------------------------------------------------------------------
   tick_type        tick_q[$];      // items waiting to be offered
   tick_result_type expect_q[$];    // predicted results, oldest first
   int unsigned  ticks_queued      = 0;
   int unsigned  result_count      = 0;
   int unsigned  mismatch_count    = 0;
   int unsigned  csr_write_count   = 0;
   int unsigned  cycle_count       = 0;
   bit           req_taken         = 1'b0;
   int unsigned  send_idle_pct     = 13;
   int unsigned  recv_idle_pct     = 65;
   int unsigned  hold_left         = 0;
   int unsigned  hold_req          = 0;
   int unsigned  hold_ack          = 0;

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 50) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                   result_count, name, got, want));
   endtask

   // ---------------------------------------------------------------------------
   // Monitor: samples both channels at the rising edge.
   // Results are checked before the new item is predicted; results are registered
   // so a result never belongs to an item taken at the same edge.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      tick_type        seen;
      tick_result_type want;
      cycle_count++;
      req_taken = req_if.valid && req_if.ready;
      if (reset === 1'b0) begin
         if (rsp_if.valid && rsp_if.ready) begin
            result_count++;
            if (expect_q.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         result_count));
            end else begin
               want = expect_q.pop_front();
               check_field("line_release", 8'(rsp_if.line_release), 8'(want.line_release));
               check_field("busy_res",     8'(rsp_if.busy_res),     8'(want.busy_res));
               check_field("byte_done",    8'(rsp_if.byte_done),    8'(want.byte_done));
               check_field("read_byte_a",  rsp_if.read_byte_a,      want.read_byte_a);
               check_field("read_byte_b",  rsp_if.read_byte_b,      want.read_byte_b);
               check_field("cmd_ignored",  8'(rsp_if.cmd_ignored),  8'(want.cmd_ignored));
            end
         end
         if (req_taken) begin
            seen.cmd     = req_if.cmd;
            seen.wr_byte = req_if.wr_byte;
            seen.line_a  = req_if.line_a;
            seen.line_b  = req_if.line_b;
            expect_q.push_back(engine_tick(seen));
         end
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.reg_index)
               CSR_LOW_TIME:      cfg_low      = csr_if.wr_data;
               CSR_WRITE_HOLD:    cfg_hold     = csr_if.wr_data;
               CSR_RECOVERY_TIME: cfg_recovery = csr_if.wr_data;
               CSR_SAMPLE_DELAY:  cfg_sample   = csr_if.wr_data;
               CSR_READ_REST:     cfg_rest     = csr_if.wr_data;
               default: ;
            endcase
            csr_write_count++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Driver: offers queued items and drives the result-side ready, all at the
   // falling edge. An item stays on the channel until it has been taken.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      tick_type nxt;
      if (!req_if.valid || req_taken) begin
         if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = tick_q.pop_front();
            req_if.valid   <= 1'b1;
            req_if.cmd     <= nxt.cmd;
            req_if.wr_byte <= nxt.wr_byte;
            req_if.line_a  <= nxt.line_a;
            req_if.line_b  <= nxt.line_b;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
   end

   // Long receiver hold-off, counted here so the sender keeps offering items.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         hold_left <= HOLD_CYCLES;
         hold_ack  <= hold_req;
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   task automatic push_tick(logic [CMD_BITS-1:0] cmd, logic [BYTE_BITS-1:0] data,
                            logic la, logic lb);
      tick_type t;
      t.cmd     = cmd;
      t.wr_byte = data;
      t.line_a  = la;
      t.line_b  = lb;
      tick_q.push_back(t);
      ticks_queued++;
   endtask

   // One whole byte transfer, started from idle and run to its done tick.
   // line_fix < 0 gives random line levels, else {line_a, line_b}.
   // noise_pct: chance of a stray command on each busy tick (ignored).
   // hit_done: a start command lands on the done tick, which still counts as busy.
   task automatic run_transfer(logic [CMD_BITS-1:0] start_cmd, logic [BYTE_BITS-1:0] data,
                               int line_fix, int unsigned noise_pct, bit hit_done);
      int unsigned         len;
      int unsigned         i;
      logic [CMD_BITS-1:0] c;
      logic [1:0]          lines;
      if (start_cmd == CMD_WRITE)
         len = 8 * (timer_count(cfg_low) + timer_count(cfg_hold) + timer_count(cfg_recovery));
      else
         len = 8 * (timer_count(cfg_low) + timer_count(cfg_sample) + 1 +
                    timer_count(cfg_rest));
      for (i = 0; i < len; i++) begin
         if (i == 0)
            c = start_cmd;
         else if (hit_done && i == len - 1)
            c = $urandom_range(1) ? CMD_WRITE : CMD_READ;
         else if ($urandom_range(99) < noise_pct)
            c = CMD_BITS'($urandom_range(3));
         else
            c = ($urandom_range(7) == 0) ? CMD_SPARE : CMD_TICK;
         lines = (line_fix < 0) ? 2'($urandom) : line_fix[1:0];
         push_tick(c, (i == 0) ? data : BYTE_BITS'($urandom), lines[1], lines[0]);
      end
   endtask

   // Start command followed by plain ticks, len items in all; the rest of the
   // transfer is left to settle_idle.
   task automatic run_partial(logic [CMD_BITS-1:0] start_cmd, int unsigned len);
      int unsigned i;
      for (i = 0; i < len; i++)
         push_tick((i == 0) ? start_cmd : CMD_TICK, BYTE_BITS'($urandom), 1'($urandom),
                   1'($urandom));
   endtask

   // Mostly well-formed transfers with random content; some idle noise.
   task automatic random_traffic(int unsigned count);
      int unsigned stop;
      stop = ticks_queued + count;
      while (ticks_queued < stop) begin
         if ($urandom_range(99) < 85) begin
            run_transfer($urandom_range(1) ? CMD_WRITE : CMD_READ, BYTE_BITS'($urandom), -1,
                         ($urandom_range(99) < 30) ? 32'd10 : 32'd0,
                         $urandom_range(99) < 20);
            repeat ($urandom_range(3))
               push_tick(CMD_TICK, BYTE_BITS'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            repeat ($urandom_range(1, 6))
               push_tick($urandom_range(1) ? CMD_SPARE : CMD_TICK, BYTE_BITS'($urandom),
                         1'($urandom), 1'($urandom));
         end
      end
   endtask

   // Waits until every queued item has been taken and answered.
   task automatic wait_drained();
      while (result_count != ticks_queued)
         @(negedge clock);
   endtask

   // Waits for every item to be taken and answered, and tops up with plain
   // ticks should a transfer still be running.
   task automatic settle_idle();
      forever begin
         wait_drained();
         if (eng_phase == PH_IDLE) break;
         repeat (8) push_tick(CMD_TICK, BYTE_BITS'($urandom), 1'($urandom), 1'($urandom));
      end
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      int unsigned seen;
      seen = csr_write_count;
      @(negedge clock);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wr_data   <= val;
      while (csr_write_count == seen) @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Only called with the sequencer idle and nothing outstanding.
   task automatic set_timing(logic [7:0] low, logic [7:0] hold, logic [7:0] rec,
                             logic [7:0] samp, logic [7:0] rest);
      write_reg(CSR_LOW_TIME, low);
      write_reg(CSR_WRITE_HOLD, hold);
      write_reg(CSR_RECOVERY_TIME, rec);
      write_reg(CSR_SAMPLE_DELAY, samp);
      write_reg(CSR_READ_REST, rest);
   endtask

   initial begin
      int p;
      req_if.valid     = 1'b0;
      req_if.cmd       = CMD_TICK;
      req_if.wr_byte   = '0;
      req_if.line_a    = 1'b0;
      req_if.line_b    = 1'b0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.reg_index = CSR_LOW_TIME;
      csr_if.wr_data   = '0;
      reset            = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Register defaults straight out of reset: the first read slot runs on
      // them, then the timing shrinks mid-transfer (taken at the next load).
      run_partial(CMD_READ, timer_count(cfg_low) + timer_count(cfg_sample) + 1 +
                            timer_count(cfg_rest));
      wait_drained();
      write_reg(CSR_LOW_TIME, 8'd0);
      write_reg(CSR_SAMPLE_DELAY, 8'd0);
      write_reg(CSR_READ_REST, 8'd0);
      settle_idle();

      // Write hold and recovery still at their defaults for the first slot.
      run_partial(CMD_WRITE, timer_count(cfg_low) + timer_count(cfg_hold) +
                             timer_count(cfg_recovery));
      wait_drained();
      write_reg(CSR_WRITE_HOLD, 8'd0);
      write_reg(CSR_RECOVERY_TIME, 8'd0);
      settle_idle();

      // All timing registers zero: every phase lasts one tick.
      set_timing(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      push_tick(CMD_TICK, 8'hFF, 1'b1, 1'b1);
      push_tick(CMD_SPARE, 8'h00, 1'b0, 1'b0);
      run_transfer(CMD_WRITE, 8'h00, 0, 100, 1'b0);   // stray command on every busy tick
      run_transfer(CMD_WRITE, 8'hFF, 3, 0, 1'b1);     // start on the done tick is ignored
      run_transfer(CMD_READ, 8'h00, 3, 0, 1'b1);      // back to back after done
      run_transfer(CMD_READ, 8'hFF, 0, 50, 1'b0);
      run_transfer(CMD_WRITE, 8'hA5, -1, 0, 1'b0);
      run_transfer(CMD_READ, 8'h5A, -1, 0, 1'b1);
      push_tick(CMD_SPARE, 8'hFF, 1'b1, 1'b0);
      random_traffic(60);
      settle_idle();

      set_timing(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
      random_traffic(60);
      settle_idle();

      for (p = 0; p < 7; p++) begin
         if (p == 2) begin
            send_idle_pct = 65;
            recv_idle_pct = 13;
         end
         if (p == 5) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_timing(CSR_DATA_BITS'($urandom_range(5)), CSR_DATA_BITS'($urandom_range(5)),
                    CSR_DATA_BITS'($urandom_range(5)), CSR_DATA_BITS'($urandom_range(5)),
                    CSR_DATA_BITS'($urandom_range(5)));
         random_traffic(50);
         // receiver holds off while items keep coming, so the input backs up
         if (p == 2 || p == 5) hold_req++;
         settle_idle();
      end

      // Largest count: a 255-tick low phase, then short timing for the rest.
      set_timing(8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
      run_partial(CMD_WRITE, 255);
      wait_drained();
      write_reg(CSR_LOW_TIME, 8'd0);
      settle_idle();

      set_timing(CSR_DATA_BITS'($urandom_range(3)), CSR_DATA_BITS'($urandom_range(3)),
                 CSR_DATA_BITS'($urandom_range(3)), CSR_DATA_BITS'($urandom_range(3)),
                 CSR_DATA_BITS'($urandom_range(3)));
      random_traffic(60);
      settle_idle();

      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && expect_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/dowbe_pkg.sv
hw/rtl/dowbe_ifs.sv
hw/rtl/dual_one_wire_byte_engine_unit.sv
tb/dual_one_wire_byte_engine_unit_tb.sv
